// ===== rtl/i2c_master_transaction_sequencer_unit_assert.svh =====
// Assertion macros for the I2C transaction sequencer.
// All of them sample on clk and are off while rst_n is low.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define I2CSEQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define I2CSEQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/i2cseq_pkg.sv =====
package i2cseq_pkg;

    localparam int PAYLOAD_DEPTH = 16;
    localparam int CNT_W  = $clog2(PAYLOAD_DEPTH + 1);
    localparam int IDX_W  = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int SEND_W = $clog2(PAYLOAD_DEPTH + 3);

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_EVENT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_RSTRT = 3'd3,
        ACT_RCEN  = 3'd4,
        ACT_ACK   = 3'd5,
        ACT_NACK  = 3'd6,
        ACT_STOP  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_BUSY = 2'd1,
        ERR_FULL = 2'd2,
        ERR_RSVD = 2'd3
    } err_t;

    typedef struct packed {
        err_t       error;
        logic       busy_res;
        logic       done_res;
        logic       rd_last;
        logic [7:0] rd_index;
        logic [7:0] rd_byte;
        logic       rd_valid;
        logic [7:0] tx_byte;
        action_t    bus_action;
    } result_t;

endpackage

// ===== rtl/i2c_master_transaction_sequencer_unit.sv =====
// I2C master write/read sequencer. Each input transaction (push byte, start write,
// start read, or a bus event from the I2C peripheral) is decoded against the
// current phase and yields exactly one result transaction. One transaction is
// taken per clock while s_tready is high; its result is registered into the result
// queue when the input is taken. A two-entry result queue lets the input side keep
// taking transactions while one result waits for m_tready, so s_tready drops only
// when both entries are held. The write payload buffer holds PAYLOAD_DEPTH bytes
// and is emptied only at reset or when a write completes.
`include "i2c_master_transaction_sequencer_unit_assert.svh"

module i2c_master_transaction_sequencer_unit
    import i2cseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] data_byte, [15:8] slave_addr, [23:16] command, [31:24] read_count,
    // [32] rx_full, [40:33] rx_byte, [47:41] zero
    input  logic [47:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] bus_action, [10:3] tx_byte, [11] rd_valid, [19:12] rd_byte,
    // [27:20] rd_index, [28] done_res, [29] busy_res, [31:30] error
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WRITE,
        PH_FINISH,
        PH_RADDR_W,
        PH_RCMD,
        PH_RRESTART,
        PH_RADDR_R,
        PH_RSTART,
        PH_RACK,
        PH_RNACK
    } phase_t;

    mode_t       mode;
    logic [7:0]  data_byte;
    logic [7:0]  slave_addr;
    logic [7:0]  command;
    logic [7:0]  read_count;
    logic        rx_full;
    logic [7:0]  rx_byte;

    assign mode       = mode_t'(s_tuser);
    assign data_byte  = s_tdata[7:0];
    assign slave_addr = s_tdata[15:8];
    assign command    = s_tdata[23:16];
    assign read_count = s_tdata[31:24];
    assign rx_full    = s_tdata[32];
    assign rx_byte    = s_tdata[40:33];

    phase_t             phase_reg, phase_next;
    logic               is_read_reg, is_read_next;
    logic [7:0]         addr_reg, addr_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SEND_W-1:0]  send_pos_reg, send_pos_next;
    logic [7:0]         recv_pos_reg, recv_pos_next;
    logic [7:0]         recv_total_reg, recv_total_next;
    logic [7:0]         store_reg [PAYLOAD_DEPTH];

    result_t            res_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         fill_reg;

    logic               in_fire, out_fire, store_we;
    logic [IDX_W-1:0]   send_idx;
    result_t            res;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (fill_reg != 2'd2);
    assign m_tvalid = (fill_reg != 2'd0);
    assign m_tdata  = {res_reg[rd_ptr_reg].error, res_reg[rd_ptr_reg].busy_res,
                       res_reg[rd_ptr_reg].done_res, res_reg[rd_ptr_reg].rd_index,
                       res_reg[rd_ptr_reg].rd_byte, res_reg[rd_ptr_reg].rd_valid,
                       res_reg[rd_ptr_reg].tx_byte, res_reg[rd_ptr_reg].bus_action};
    assign m_tlast  = res_reg[rd_ptr_reg].rd_last;

    // payload byte at send_pos - 2 (address and command go first)
    assign send_idx = IDX_W'(send_pos_reg - SEND_W'(2));

    always_comb
    begin
        res             = '0;
        res.bus_action  = ACT_NONE;
        res.error       = ERR_NONE;
        phase_next      = phase_reg;
        is_read_next    = is_read_reg;
        addr_next       = addr_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        send_pos_next   = send_pos_reg;
        recv_pos_next   = recv_pos_reg;
        recv_total_next = recv_total_reg;
        store_we        = 1'b0;

        case (mode)
            MODE_PUSH:
            begin
                if (count_reg >= CNT_W'(PAYLOAD_DEPTH))
                    res.error = ERR_FULL;
                else
                begin
                    store_we   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_WRITE, MODE_READ:
            begin
                if (phase_reg != PH_IDLE)
                    res.error = ERR_BUSY;
                else
                begin
                    addr_next      = slave_addr;
                    cmd_next       = command;
                    res.bus_action = ACT_START;
                    if (mode == MODE_WRITE)
                    begin
                        is_read_next  = 1'b0;
                        send_pos_next = '0;
                        phase_next    = PH_WRITE;
                    end
                    else
                    begin
                        is_read_next    = 1'b1;
                        recv_pos_next   = '0;
                        recv_total_next = (read_count == 8'd0) ? 8'd1 : read_count;
                        phase_next      = PH_RADDR_W;
                    end
                end
            end
            MODE_EVENT:
            begin
                case (phase_reg)
                    PH_WRITE:
                    begin
                        if ({1'b0, send_pos_reg} <
                            (SEND_W + 1)'(count_reg) + (SEND_W + 1)'(2))
                        begin
                            res.bus_action = ACT_SEND;
                            if (send_pos_reg == SEND_W'(0))
                                res.tx_byte = addr_reg;
                            else if (send_pos_reg == SEND_W'(1))
                                res.tx_byte = cmd_reg;
                            else
                                res.tx_byte = store_reg[send_idx];
                            send_pos_next = send_pos_reg + SEND_W'(1);
                        end
                        else
                        begin
                            res.bus_action = ACT_STOP;
                            phase_next     = PH_FINISH;
                        end
                    end
                    PH_FINISH:
                    begin
                        res.done_res = 1'b1;
                        if (!is_read_reg)
                            count_next = '0;
                        send_pos_next = '0;
                        recv_pos_next = '0;
                        phase_next    = PH_IDLE;
                    end
                    PH_RADDR_W:
                    begin
                        res.bus_action = ACT_SEND;
                        res.tx_byte    = addr_reg;
                        phase_next     = PH_RCMD;
                    end
                    PH_RCMD:
                    begin
                        res.bus_action = ACT_SEND;
                        res.tx_byte    = cmd_reg;
                        phase_next     = PH_RRESTART;
                    end
                    PH_RRESTART:
                    begin
                        res.bus_action = ACT_RSTRT;
                        phase_next     = PH_RADDR_R;
                    end
                    PH_RADDR_R:
                    begin
                        res.bus_action = ACT_SEND;
                        res.tx_byte    = addr_reg | 8'd1;
                        phase_next     = PH_RSTART;
                    end
                    PH_RSTART:
                    begin
                        res.bus_action = ACT_RCEN;
                        if ({1'b0, recv_pos_reg} + 9'd1 < {1'b0, recv_total_reg})
                            phase_next = PH_RACK;
                        else
                            phase_next = PH_RNACK;
                    end
                    PH_RACK:
                    begin
                        if (rx_full)
                        begin
                            res.bus_action = ACT_ACK;
                            res.rd_valid   = 1'b1;
                            res.rd_byte    = rx_byte;
                            res.rd_index   = recv_pos_reg;
                            recv_pos_next  = recv_pos_reg + 8'd1;
                            phase_next     = PH_RSTART;
                        end
                    end
                    PH_RNACK:
                    begin
                        if (rx_full)
                        begin
                            res.bus_action = ACT_NACK;
                            res.rd_valid   = 1'b1;
                            res.rd_byte    = rx_byte;
                            res.rd_index   = recv_pos_reg;
                            res.rd_last    = 1'b1;
                            recv_pos_next  = '0;
                            phase_next     = PH_FINISH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            is_read_reg    <= 1'b0;
            addr_reg       <= '0;
            cmd_reg        <= '0;
            count_reg      <= '0;
            send_pos_reg   <= '0;
            recv_pos_reg   <= '0;
            recv_total_reg <= '0;
            res_reg[0]     <= '0;
            res_reg[1]     <= '0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            fill_reg       <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg           <= phase_next;
                is_read_reg         <= is_read_next;
                addr_reg            <= addr_next;
                cmd_reg             <= cmd_next;
                count_reg           <= count_next;
                send_pos_reg        <= send_pos_next;
                recv_pos_reg        <= recv_pos_next;
                recv_total_reg      <= recv_total_next;
                res_reg[wr_ptr_reg] <= res;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (out_fire)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, in_fire} - {1'b0, out_fire};
        end
    end

    // payload buffer carries no reset
    always_ff @(posedge clk)
    begin
        if (in_fire && store_we)
            store_reg[count_reg[IDX_W-1:0]] <= data_byte;
    end

    `I2CSEQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(PAYLOAD_DEPTH),
        "payload count beyond buffer depth")
    `I2CSEQ_ASSERT_NXT(a_full_push_drop,
        in_fire && mode == MODE_PUSH && count_reg == CNT_W'(PAYLOAD_DEPTH),
        $stable(count_reg), "push into full buffer changed the count")
    `I2CSEQ_ASSERT_NXT(a_start_leaves_idle,
        in_fire && phase_reg == PH_IDLE && (mode == MODE_WRITE || mode == MODE_READ),
        phase_reg != PH_IDLE && m_tvalid, "accepted start did not leave idle")
    `I2CSEQ_ASSERT_IMP(a_queue_fill, 1'b1,
        fill_reg != 2'd3 && ((fill_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg)),
        "result queue pointers out of step with fill")

endmodule

// ===== bench/i2c_master_transaction_sequencer_unit_test.sv =====
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_unit_test
    import i2cseq_pkg::*;
();

    localparam int RAND_ITEMS  = 1700;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int DIR_ROWS    = 23;
    localparam int DIR_IDX_W   = $clog2(DIR_ROWS);

    typedef enum int {
        SEQ_IDLE,
        SEQ_WRITE,
        SEQ_FINISH,
        SEQ_ADDR_W,
        SEQ_CMD,
        SEQ_RESTART,
        SEQ_ADDR_R,
        SEQ_RECV_EN,
        SEQ_ACK,
        SEQ_NACK
    } seq_phase_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] data_byte;
        logic [7:0] slave_addr;
        logic [7:0] command;
        logic [7:0] read_count;
        logic       rx_full;
        logic [7:0] rx_byte;
    } txn_t;

    typedef struct {
        txn_t    t;
        int      reps;
        bit      chk;
        action_t e_act;
        err_t    e_err;
        bit      e_done;
        bit      e_busy;
    } dir_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = MODE_PUSH;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // sequencer state as predicted
    seq_phase_t  seq_phase = SEQ_IDLE;
    bit          rd_mode   = 1'b0;
    logic [7:0]  addr_q    = '0;
    logic [7:0]  cmd_q     = '0;
    logic [7:0]  payload [PAYLOAD_DEPTH];
    int          fill_cnt  = 0;
    int          tx_pos    = 0;
    logic [7:0]  rx_pos    = '0;
    logic [7:0]  rx_total  = '0;

    result_t     seq_expect_q [$];
    int          error_cnt = 0;
    int          cycle_cnt = 0;
    int          rx_hold   = 0;
    bit          tx_calm   = 1'b0;
    bit          rx_calm   = 1'b0;

    // txn: mode, data_byte, slave_addr, command, read_count, rx_full, rx_byte
    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{'{MODE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF}, 1, 1'b1,
          ACT_NONE, ERR_NONE, 1'b0, 1'b0},
        '{'{MODE_PUSH, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00}, 1, 1'b1,
          ACT_NONE, ERR_NONE, 1'b0, 1'b0},
        '{'{MODE_PUSH, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF}, 1, 1'b1,
          ACT_NONE, ERR_NONE, 1'b0, 1'b0},
        '{'{MODE_WRITE, 8'h00, 8'hFE, 8'h00, 8'h00, 1'b0, 8'h00}, 1, 1'b1,
          ACT_START, ERR_NONE, 1'b0, 1'b1},
        '{'{MODE_READ, 8'h00, 8'h20, 8'h10, 8'h03, 1'b0, 8'h00}, 1, 1'b1,
          ACT_NONE, ERR_BUSY, 1'b0, 1'b1},
        // appended while the write is still on the address byte
        '{'{MODE_PUSH, 8'hA5, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 1, 1'b1,
          ACT_NONE, ERR_NONE, 1'b0, 1'b1},
        '{'{MODE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 6, 1'b0,
          ACT_NONE, ERR_NONE, 1'b0, 1'b0},
        '{'{MODE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 1, 1'b1,
          ACT_NONE, ERR_NONE, 1'b1, 1'b0},
        // zero count reads one byte
        '{'{MODE_READ, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00}, 1, 1'b1,
          ACT_START, ERR_NONE, 1'b0, 1'b1},
        '{'{MODE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00}, 5, 1'b0,
          ACT_NONE, ERR_NONE, 1'b0, 1'b0},
        '{'{MODE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'hAA}, 1, 1'b1,
          ACT_NONE, ERR_NONE, 1'b0, 1'b1},
        '{'{MODE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF}, 1, 1'b0,
          ACT_NONE, ERR_NONE, 1'b0, 1'b0},
        '{'{MODE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00}, 1, 1'b1,
          ACT_NONE, ERR_NONE, 1'b1, 1'b0},
        '{'{MODE_PUSH, 8'h5A, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 16, 1'b1,
          ACT_NONE, ERR_NONE, 1'b0, 1'b0},
        '{'{MODE_PUSH, 8'hC3, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 1, 1'b1,
          ACT_NONE, ERR_FULL, 1'b0, 1'b0},
        // two-byte read: ACK path then NACK
        '{'{MODE_READ, 8'h00, 8'h3C, 8'h80, 8'h02, 1'b0, 8'h00}, 1, 1'b1,
          ACT_START, ERR_NONE, 1'b0, 1'b1},
        '{'{MODE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00}, 5, 1'b0,
          ACT_NONE, ERR_NONE, 1'b0, 1'b0},
        '{'{MODE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00}, 1, 1'b0,
          ACT_NONE, ERR_NONE, 1'b0, 1'b0},
        '{'{MODE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h81}, 2, 1'b0,
          ACT_NONE, ERR_NONE, 1'b0, 1'b0},
        '{'{MODE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00}, 1, 1'b1,
          ACT_NONE, ERR_NONE, 1'b1, 1'b0},
        // write with a full buffer, left running into the random part
        '{'{MODE_WRITE, 8'h00, 8'h50, 8'h01, 8'h00, 1'b0, 8'h00}, 1, 1'b1,
          ACT_START, ERR_NONE, 1'b0, 1'b1},
        '{'{MODE_WRITE, 8'h00, 8'h52, 8'h02, 8'h00, 1'b0, 8'h00}, 1, 1'b1,
          ACT_NONE, ERR_BUSY, 1'b0, 1'b1},
        '{'{MODE_PUSH, 8'h11, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 1, 1'b1,
          ACT_NONE, ERR_FULL, 1'b0, 1'b1}
    };

    i2c_master_transaction_sequencer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    function automatic result_t step_sequencer(input txn_t it);
        result_t r;
        r = '0;
        case (it.mode)
            MODE_PUSH:
            begin
                if (fill_cnt >= PAYLOAD_DEPTH)
                begin
                    r.error = ERR_FULL;
                end
                else
                begin
                    payload[IDX_W'(fill_cnt)] = it.data_byte;
                    fill_cnt++;
                end
            end
            MODE_WRITE, MODE_READ:
            begin
                if (seq_phase != SEQ_IDLE)
                begin
                    r.error = ERR_BUSY;
                end
                else
                begin
                    addr_q       = it.slave_addr;
                    cmd_q        = it.command;
                    r.bus_action = ACT_START;
                    if (it.mode == MODE_WRITE)
                    begin
                        rd_mode   = 1'b0;
                        tx_pos    = 0;
                        seq_phase = SEQ_WRITE;
                    end
                    else
                    begin
                        rd_mode   = 1'b1;
                        rx_pos    = '0;
                        rx_total  = (it.read_count == 8'd0) ? 8'd1 : it.read_count;
                        seq_phase = SEQ_ADDR_W;
                    end
                end
            end
            default:
            begin
                case (seq_phase)
                    SEQ_WRITE:
                    begin
                        // address, command, then every buffered byte, then stop
                        if (tx_pos < fill_cnt + 2)
                        begin
                            r.bus_action = ACT_SEND;
                            if (tx_pos == 0)
                                r.tx_byte = addr_q;
                            else if (tx_pos == 1)
                                r.tx_byte = cmd_q;
                            else
                                r.tx_byte = payload[IDX_W'(tx_pos - 2)];
                            tx_pos++;
                        end
                        else
                        begin
                            r.bus_action = ACT_STOP;
                            seq_phase    = SEQ_FINISH;
                        end
                    end
                    SEQ_FINISH:
                    begin
                        r.done_res = 1'b1;
                        if (!rd_mode)
                            fill_cnt = 0;
                        tx_pos    = 0;
                        rx_pos    = '0;
                        seq_phase = SEQ_IDLE;
                    end
                    SEQ_ADDR_W:
                    begin
                        r.bus_action = ACT_SEND;
                        r.tx_byte    = addr_q;
                        seq_phase    = SEQ_CMD;
                    end
                    SEQ_CMD:
                    begin
                        r.bus_action = ACT_SEND;
                        r.tx_byte    = cmd_q;
                        seq_phase    = SEQ_RESTART;
                    end
                    SEQ_RESTART:
                    begin
                        r.bus_action = ACT_RSTRT;
                        seq_phase    = SEQ_ADDR_R;
                    end
                    SEQ_ADDR_R:
                    begin
                        r.bus_action = ACT_SEND;
                        r.tx_byte    = {addr_q[7:1], 1'b1};
                        seq_phase    = SEQ_RECV_EN;
                    end
                    SEQ_RECV_EN:
                    begin
                        r.bus_action = ACT_RCEN;
                        seq_phase = (int'(rx_pos) + 1 < int'(rx_total)) ? SEQ_ACK : SEQ_NACK;
                    end
                    SEQ_ACK:
                    begin
                        if (it.rx_full)
                        begin
                            r.bus_action = ACT_ACK;
                            r.rd_valid   = 1'b1;
                            r.rd_byte    = it.rx_byte;
                            r.rd_index   = rx_pos;
                            rx_pos       = rx_pos + 8'd1;
                            seq_phase    = SEQ_RECV_EN;
                        end
                    end
                    SEQ_NACK:
                    begin
                        if (it.rx_full)
                        begin
                            r.bus_action = ACT_NACK;
                            r.rd_valid   = 1'b1;
                            r.rd_byte    = it.rx_byte;
                            r.rd_index   = rx_pos;
                            r.rd_last    = 1'b1;
                            rx_pos       = '0;
                            seq_phase    = SEQ_FINISH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase
        r.busy_res = (seq_phase != SEQ_IDLE);
        return r;
    endfunction

    task automatic drive_txn(input txn_t it, input bit typed, input result_t typed_res);
        int      gap;
        result_t want;
        gap = tx_calm ? 0 : int'($urandom_range(0, 15));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {7'd0, it.rx_byte, it.rx_full, it.read_count, it.command,
                     it.slave_addr, it.data_byte};
        do @(posedge clk); while (!s_tready);
        want = step_sequencer(it);
        seq_expect_q.push_back(typed ? typed_res : want);
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
    endtask

    // result side: check each transaction, then hold tready low for a drawn gap
    always @(posedge clk)
    begin : result_chk
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.bus_action = action_t'(m_tdata[2:0]);
                got.tx_byte    = m_tdata[10:3];
                got.rd_valid   = m_tdata[11];
                got.rd_byte    = m_tdata[19:12];
                got.rd_index   = m_tdata[27:20];
                got.done_res   = m_tdata[28];
                got.busy_res   = m_tdata[29];
                got.error      = err_t'(m_tdata[31:30]);
                got.rd_last    = m_tlast;
                if (seq_expect_q.size() == 0)
                begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS)
                        $display("unexpected result: m_tdata=%h m_tlast=%b",
                                 m_tdata, m_tlast);
                end
                else
                begin
                    want = seq_expect_q.pop_front();
                    if (got.bus_action !== want.bus_action || got.tx_byte !== want.tx_byte ||
                        got.rd_valid !== want.rd_valid || got.rd_byte !== want.rd_byte ||
                        got.rd_index !== want.rd_index || got.rd_last !== want.rd_last ||
                        got.done_res !== want.done_res || got.busy_res !== want.busy_res ||
                        got.error !== want.error)
                    begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS)
                        begin
                            $write("mismatch exp: act=%0d tx=%h rv=%b rb=%h ri=%0d rl=%b ",
                                   want.bus_action, want.tx_byte, want.rd_valid,
                                   want.rd_byte, want.rd_index, want.rd_last);
                            $display("done=%b busy=%b err=%0d",
                                     want.done_res, want.busy_res, want.error);
                            $write("         got: act=%0d tx=%h rv=%b rb=%h ri=%0d rl=%b ",
                                   got.bus_action, got.tx_byte, got.rd_valid,
                                   got.rd_byte, got.rd_index, got.rd_last);
                            $display("done=%b busy=%b err=%0d",
                                     got.done_res, got.busy_res, got.error);
                        end
                    end
                end
                if ($urandom_range(0, 49) == 0)
                    rx_calm = !rx_calm;
                rx_hold = rx_calm ? 0 : int'($urandom_range(0, 15));
                if (rx_hold != 0)
                    m_tready <= 1'b0;
            end
            else if (!m_tready)
            begin
                if (rx_hold <= 1)
                    m_tready <= 1'b1;
                else
                    rx_hold--;
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("i2c_master_transaction_sequencer_unit verification failed");
        $finish;
    end

    initial
    begin
        txn_t     it;
        result_t  exp_res;
        dir_row_t row;
        int       pick;
        int       push_burst;
        bit       long_done;
        push_burst = 0;
        long_done  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row                = dir_tab[DIR_IDX_W'(i)];
            exp_res            = '0;
            exp_res.bus_action = row.e_act;
            exp_res.error      = row.e_err;
            exp_res.done_res   = row.e_done;
            exp_res.busy_res   = row.e_busy;
            repeat (row.reps) drive_txn(row.t, row.chk, exp_res);
        end

        exp_res = '0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            it.data_byte  = 8'($urandom_range(0, 255));
            it.slave_addr = 8'($urandom_range(0, 255));
            it.command    = 8'($urandom_range(0, 255));
            it.read_count = 8'($urandom_range(0, 255));
            it.rx_byte    = 8'($urandom_range(0, 255));
            it.rx_full    = ($urandom_range(0, 7) != 0);
            pick = int'($urandom_range(0, 99));
            if (push_burst > 0)
            begin
                it.mode = MODE_PUSH;
                push_burst--;
            end
            else if (seq_phase == SEQ_IDLE)
            begin
                // bursts run the buffer into its full state
                if (pick < 5)
                begin
                    it.mode    = MODE_PUSH;
                    push_burst = 19;
                end
                else if (pick < 45)
                    it.mode = MODE_PUSH;
                else if (pick < 70)
                    it.mode = MODE_WRITE;
                else if (pick < 92)
                    it.mode = MODE_READ;
                else
                    it.mode = MODE_EVENT;
            end
            else
            begin
                if (pick < 84)
                    it.mode = MODE_EVENT;
                else if (pick < 94)
                    it.mode = MODE_PUSH;
                else
                    it.mode = ($urandom_range(0, 1) != 0) ? MODE_WRITE : MODE_READ;
            end
            if (it.mode == MODE_READ)
            begin
                pick = int'($urandom_range(0, 63));
                // one read of the largest count, so every index bit toggles
                if (!long_done && seq_phase == SEQ_IDLE && n > RAND_ITEMS / 3)
                begin
                    it.read_count = 8'hFF;
                    long_done     = 1'b1;
                end
                else if (pick == 0)
                    it.read_count = 8'hFF;
                else if (pick >= 4)
                    it.read_count = 8'($urandom_range(0, 6));
            end
            drive_txn(it, 1'b0, exp_res);
        end
        s_tvalid <= 1'b0;

        while (seq_expect_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_cnt == 0)
            $display("i2c_master_transaction_sequencer_unit verification clean");
        else
            $display("i2c_master_transaction_sequencer_unit verification failed");
        $finish;
    end

endmodule

// ===== i2c_master_transaction_sequencer_unit.f =====
+incdir+rtl
rtl/i2cseq_pkg.sv
rtl/i2c_master_transaction_sequencer_unit.sv
bench/i2c_master_transaction_sequencer_unit_test.sv
